FILE: design/slu_pkg.sv
// Shared types and constants for the symbol language lexer.
// Used by slu_core, slu_queue and symbol_language_lexer_unit; no dependencies.
package slu_pkg;

   localparam int PositionBits   = 16;
   localparam int WordBits       = 16;
   localparam int PrefixBits     = 24;
   localparam int QueueDepth     = 4;
   localparam int QueuePtrBits   = $clog2(QueueDepth);
   localparam int QueueCountBits = $clog2(QueueDepth + 1);

   localparam logic [3:0] KIND_VARIABLE = 4'd0;
   localparam logic [3:0] KIND_KEYWORD  = 4'd1;
   localparam logic [3:0] KIND_LPAREN   = 4'd2;
   localparam logic [3:0] KIND_RPAREN   = 4'd3;
   localparam logic [3:0] KIND_LSQUARE  = 4'd4;
   localparam logic [3:0] KIND_RSQUARE  = 4'd5;
   localparam logic [3:0] KIND_SEMI     = 4'd6;
   localparam logic [3:0] KIND_END      = 4'd7;
   localparam logic [3:0] KIND_INVALID  = 4'd8;

   localparam logic [1:0] KW_FUN = 2'd0;
   localparam logic [1:0] KW_LET = 2'd1;
   localparam logic [1:0] KW_IN  = 2'd2;
   localparam logic [1:0] KW_REC = 2'd3;

   localparam logic [PrefixBits-1:0] TEXT_FUN = "fun";
   localparam logic [PrefixBits-1:0] TEXT_LET = "let";
   localparam logic [PrefixBits-1:0] TEXT_IN  = {8'h00, "in"};
   localparam logic [PrefixBits-1:0] TEXT_REC = "rec";

   localparam logic [7:0] CHAR_NUL     = 8'h00;
   localparam logic [7:0] CHAR_EOS     = 8'hFF;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_CR      = 8'h0D;
   localparam logic [7:0] CHAR_FIRST   = 8'h21;
   localparam logic [7:0] CHAR_LAST    = 8'h7E;
   localparam logic [7:0] CHAR_HASH    = "#";
   localparam logic [7:0] CHAR_LPAREN  = "(";
   localparam logic [7:0] CHAR_RPAREN  = ")";
   localparam logic [7:0] CHAR_LSQUARE = "[";
   localparam logic [7:0] CHAR_RSQUARE = "]";
   localparam logic [7:0] CHAR_SEMI    = ";";

   typedef enum logic [1:0] {
      MODE_IDLE    = 2'd0,
      MODE_WORD    = 2'd1,
      MODE_COMMENT = 2'd2,
      MODE_HALTED  = 2'd3
   } mode_type;

   typedef struct packed {
      logic [3:0]          kind;
      logic [1:0]          keyword;
      logic [WordBits-1:0] start;
      logic [WordBits-1:0] length;
      logic                last;
   } result_type;

   typedef struct packed {
      logic [1:0]       num;
      result_type [1:0] res;
   } push_type;

   typedef struct packed {
      logic not_empty;
      logic room_for_two;
   } queue_status_type;

endpackage

FILE: design/slu_core.sv
// Lexer state and token generation for one source byte per transaction.
// Depends on slu_pkg.
module slu_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              go,
   input  logic [7:0]        char_byte,
   output slu_pkg::push_type push
);

   slu_pkg::mode_type                 mode_ff, mode_in;
   logic [slu_pkg::PositionBits-1:0]  pos_ff, pos_in;
   logic [slu_pkg::PositionBits-1:0]  start_ff, start_in;
   logic [slu_pkg::WordBits-1:0]      len_ff, len_in;
   logic [slu_pkg::PrefixBits-1:0]    prefix_ff, prefix_in;

   logic       is_end, is_space, is_hash, is_punct, is_word, is_invalid;
   logic       ending_word, idle_active, idle_has;
   logic [3:0] punct_kind;
   slu_pkg::result_type word_res, idle_res;

   always_comb begin
      is_punct   = 1'b1;
      punct_kind = slu_pkg::KIND_LPAREN;
      case (char_byte)
         slu_pkg::CHAR_LPAREN:  punct_kind = slu_pkg::KIND_LPAREN;
         slu_pkg::CHAR_RPAREN:  punct_kind = slu_pkg::KIND_RPAREN;
         slu_pkg::CHAR_LSQUARE: punct_kind = slu_pkg::KIND_LSQUARE;
         slu_pkg::CHAR_RSQUARE: punct_kind = slu_pkg::KIND_RSQUARE;
         slu_pkg::CHAR_SEMI:    punct_kind = slu_pkg::KIND_SEMI;
         default:               is_punct   = 1'b0;
      endcase
   end

   assign is_end   = (char_byte == slu_pkg::CHAR_NUL) || (char_byte == slu_pkg::CHAR_EOS);
   assign is_space = (char_byte == slu_pkg::CHAR_SPACE) ||
                     ((char_byte >= slu_pkg::CHAR_TAB) && (char_byte <= slu_pkg::CHAR_CR));
   assign is_hash  = (char_byte == slu_pkg::CHAR_HASH);
   assign is_word  = (char_byte >= slu_pkg::CHAR_FIRST) && (char_byte <= slu_pkg::CHAR_LAST) &&
                     !is_punct && !is_hash;
   assign is_invalid = !is_end && !is_space && !is_hash && !is_punct && !is_word;

   assign ending_word = (mode_ff == slu_pkg::MODE_WORD) && !is_word;
   assign idle_active = (mode_ff == slu_pkg::MODE_IDLE) || ending_word;

   always_comb begin
      mode_in = mode_ff;
      unique case (mode_ff)
         slu_pkg::MODE_IDLE, slu_pkg::MODE_WORD: begin
            if (mode_ff == slu_pkg::MODE_WORD && is_word) begin
               mode_in = slu_pkg::MODE_WORD;
            end else if (is_end) begin
               mode_in = slu_pkg::MODE_IDLE;
            end else if (is_hash) begin
               mode_in = slu_pkg::MODE_COMMENT;
            end else if (is_word) begin
               mode_in = slu_pkg::MODE_WORD;
            end else if (is_invalid) begin
               mode_in = slu_pkg::MODE_HALTED;
            end else begin
               mode_in = slu_pkg::MODE_IDLE;
            end
         end
         slu_pkg::MODE_COMMENT: begin
            if (is_hash || is_end) begin
               mode_in = slu_pkg::MODE_IDLE;
            end
         end
         slu_pkg::MODE_HALTED: begin
            if (is_end) begin
               mode_in = slu_pkg::MODE_IDLE;
            end
         end
         default: mode_in = slu_pkg::MODE_IDLE;
      endcase
   end

   always_comb begin
      word_res         = '0;
      word_res.kind    = slu_pkg::KIND_VARIABLE;
      word_res.start   = slu_pkg::WordBits'(start_ff);
      word_res.length  = len_ff;
      if (len_ff == slu_pkg::WordBits'(3) && prefix_ff == slu_pkg::TEXT_FUN) begin
         word_res.kind    = slu_pkg::KIND_KEYWORD;
         word_res.keyword = slu_pkg::KW_FUN;
      end else if (len_ff == slu_pkg::WordBits'(3) && prefix_ff == slu_pkg::TEXT_LET) begin
         word_res.kind    = slu_pkg::KIND_KEYWORD;
         word_res.keyword = slu_pkg::KW_LET;
      end else if (len_ff == slu_pkg::WordBits'(2) && prefix_ff == slu_pkg::TEXT_IN) begin
         word_res.kind    = slu_pkg::KIND_KEYWORD;
         word_res.keyword = slu_pkg::KW_IN;
      end else if (len_ff == slu_pkg::WordBits'(3) && prefix_ff == slu_pkg::TEXT_REC) begin
         word_res.kind    = slu_pkg::KIND_KEYWORD;
         word_res.keyword = slu_pkg::KW_REC;
      end

      idle_res = '0;
      idle_has = 1'b0;
      if (is_end) begin
         idle_res.kind = slu_pkg::KIND_END;
         idle_has      = 1'b1;
      end else if (is_punct) begin
         idle_res.kind = punct_kind;
         idle_has      = 1'b1;
      end else if (is_invalid) begin
         idle_res.kind = slu_pkg::KIND_INVALID;
         idle_has      = 1'b1;
      end

      push = '0;
      if (go) begin
         unique case (mode_ff)
            slu_pkg::MODE_HALTED, slu_pkg::MODE_COMMENT: begin
               if (is_end) begin
                  push.num         = 2'd1;
                  push.res[0]      = '0;
                  push.res[0].kind = slu_pkg::KIND_END;
                  push.res[0].last = 1'b1;
               end
            end
            slu_pkg::MODE_IDLE, slu_pkg::MODE_WORD: begin
               if (ending_word) begin
                  push.res[0]      = word_res;
                  push.res[1]      = idle_res;
                  push.num         = idle_has ? 2'd2 : 2'd1;
                  push.res[0].last = !idle_has;
                  push.res[1].last = idle_has;
               end else if (idle_active && idle_has) begin
                  push.res[0]      = idle_res;
                  push.res[0].last = 1'b1;
                  push.num         = 2'd1;
               end
            end
            default: push = '0;
         endcase
      end
   end

   always_comb begin
      pos_in    = pos_ff + slu_pkg::PositionBits'(1);
      start_in  = start_ff;
      len_in    = len_ff;
      prefix_in = prefix_ff;
      if ((mode_ff == slu_pkg::MODE_HALTED || mode_ff == slu_pkg::MODE_COMMENT) && is_end) begin
         pos_in    = '0;
         start_in  = '0;
         len_in    = '0;
         prefix_in = '0;
      end else if (mode_ff == slu_pkg::MODE_WORD && is_word) begin
         if (len_ff < slu_pkg::WordBits'(3)) begin
            prefix_in = {prefix_ff[slu_pkg::PrefixBits-9:0], char_byte};
         end
         if (len_ff != '1) begin
            len_in = len_ff + slu_pkg::WordBits'(1);
         end
      end else if (idle_active) begin
         if (is_end || is_invalid) begin
            start_in  = '0;
            len_in    = '0;
            prefix_in = '0;
            if (is_end) begin
               pos_in = '0;
            end
         end else if (is_word) begin
            start_in  = pos_ff;
            len_in    = slu_pkg::WordBits'(1);
            prefix_in = slu_pkg::PrefixBits'(char_byte);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= slu_pkg::MODE_IDLE;
         pos_ff    <= '0;
         start_ff  <= '0;
         len_ff    <= '0;
         prefix_ff <= '0;
      end else if (go) begin
         mode_ff   <= mode_in;
         pos_ff    <= pos_in;
         start_ff  <= start_in;
         len_ff    <= len_in;
         prefix_ff <= prefix_in;
      end
   end

endmodule

FILE: design/slu_queue.sv
// Result queue: takes up to two tokens per cycle, hands out one per transaction.
// Depends on slu_pkg.
module slu_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  slu_pkg::push_type         push,
   input  logic                      pop,
   output slu_pkg::result_type       head,
   output slu_pkg::queue_status_type status
);

   slu_pkg::result_type entry_ff [slu_pkg::QueueDepth];
   logic [slu_pkg::QueuePtrBits-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [slu_pkg::QueuePtrBits-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [slu_pkg::QueueCountBits-1:0] count_ff, count_in;
   logic [slu_pkg::QueuePtrBits-1:0]   wr_next;

   assign wr_next   = wr_ptr_ff + slu_pkg::QueuePtrBits'(1);
   assign wr_ptr_in = wr_ptr_ff + slu_pkg::QueuePtrBits'(push.num);
   assign rd_ptr_in = rd_ptr_ff + slu_pkg::QueuePtrBits'(pop);
   assign count_in  = count_ff + slu_pkg::QueueCountBits'(push.num)
                      - slu_pkg::QueueCountBits'(pop);

   assign head                = entry_ff[rd_ptr_ff];
   assign status.not_empty    = (count_ff != '0);
   assign status.room_for_two = (count_ff <= slu_pkg::QueueCountBits'(slu_pkg::QueueDepth - 2));

   always_ff @(posedge clock) begin
      if (push.num != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.res[0];
      end
      if (push.num == 2'd2) begin
         entry_ff[wr_next] <= push.res[1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: design/symbol_language_lexer_unit.sv
// Symbol language lexer: one source byte per cycle in and one token per cycle out,
// unless req_stall or rsp_stall holds the flow. A byte taken on req waits in an input
// register; its tokens are then written to a four-entry queue and offered on rsp. A byte
// that ends a word and gives its own token yields two tokens for the single-token port.
// Reset: synchronous; lexer returns to idle with positions at zero, queue empties.
// Depends on slu_pkg, slu_core and slu_queue.
module symbol_language_lexer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_token_kind,
   output logic [1:0]  rsp_keyword_index,
   output logic [15:0] rsp_word_start,
   output logic [15:0] rsp_word_length,
   output logic        rsp_last_of_run
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic       lex_go, req_take, rsp_take;

   slu_pkg::push_type         push;
   slu_pkg::result_type       head;
   slu_pkg::queue_status_type status;

   assign lex_go    = in_valid_ff && status.room_for_two;
   assign req_stall = in_valid_ff && !lex_go;
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = status.not_empty;
   assign rsp_take  = rsp_valid && !rsp_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_char_byte;
      end else if (lex_go) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      in_byte_ff <= in_byte_in;
   end

   slu_core u_core (
      .clock     (clock),
      .reset     (reset),
      .go        (lex_go),
      .char_byte (in_byte_ff),
      .push      (push)
   );

   slu_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (rsp_take),
      .head   (head),
      .status (status)
   );

   assign rsp_token_kind    = head.kind;
   assign rsp_keyword_index = head.keyword;
   assign rsp_word_start    = head.start;
   assign rsp_word_length   = head.length;
   assign rsp_last_of_run   = head.last;

`ifndef SYNTHESIS
   a_pair_marks_last: assert property (@(posedge clock) disable iff (reset)
      push.num == 2'd2 |-> !push.res[0].last && push.res[1].last)
      else $error("two-token transaction marks the wrong token as last");

   a_single_is_last: assert property (@(posedge clock) disable iff (reset)
      push.num == 2'd1 |-> push.res[0].last)
      else $error("single token not marked as last");

   a_pair_starts_with_word: assert property (@(posedge clock) disable iff (reset)
      push.num == 2'd2 |-> (push.res[0].kind == slu_pkg::KIND_VARIABLE ||
                            push.res[0].kind == slu_pkg::KIND_KEYWORD))
      else $error("two-token transaction does not lead with a word");

   a_push_needs_byte: assert property (@(posedge clock) disable iff (reset)
      push.num != 2'd0 |-> in_valid_ff && status.room_for_two)
      else $error("tokens pushed without a held byte or queue room");
`endif

endmodule

FILE: tb/sv/symbol_language_lexer_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for symbol_language_lexer_unit: a directed byte table, random
// token streams with stalls and back pressure, all checked per token.
// Depends on slu_pkg and the lexer RTL; needs no other file.
module symbol_language_lexer_unit_tb;

   typedef struct packed {
      logic [7:0] char_byte;
      logic       typed;
      logic [3:0] kind;
   } stim_row_type;

   localparam logic TYPED = 1'b1;
   localparam logic FREE  = 1'b0;

   localparam int ROW_COUNT    = 26;
   localparam int RANDOM_ITEMS = 2000;
   localparam int LONG_HOLD    = 300;
   localparam int IDLE_LIMIT   = 5000;
   localparam int DRAIN_CYCLES = 20;
   localparam int MAX_REPORTS  = 10;

   localparam stim_row_type DIRECTED_ROWS [ROW_COUNT] = '{
      '{slu_pkg::CHAR_NUL,     TYPED, slu_pkg::KIND_END},
      '{slu_pkg::CHAR_LPAREN,  TYPED, slu_pkg::KIND_LPAREN},
      '{slu_pkg::CHAR_RPAREN,  TYPED, slu_pkg::KIND_RPAREN},
      '{slu_pkg::CHAR_LSQUARE, TYPED, slu_pkg::KIND_LSQUARE},
      '{slu_pkg::CHAR_RSQUARE, TYPED, slu_pkg::KIND_RSQUARE},
      '{slu_pkg::CHAR_SEMI,    TYPED, slu_pkg::KIND_SEMI},
      '{"f",                   FREE,  slu_pkg::KIND_VARIABLE},
      '{"u",                   FREE,  slu_pkg::KIND_VARIABLE},
      '{"n",                   FREE,  slu_pkg::KIND_VARIABLE},
      '{slu_pkg::CHAR_TAB,     FREE,  slu_pkg::KIND_VARIABLE},
      '{"l",                   FREE,  slu_pkg::KIND_VARIABLE},
      '{"e",                   FREE,  slu_pkg::KIND_VARIABLE},
      '{"t",                   FREE,  slu_pkg::KIND_VARIABLE},
      '{slu_pkg::CHAR_LPAREN,  FREE,  slu_pkg::KIND_VARIABLE},
      '{"i",                   FREE,  slu_pkg::KIND_VARIABLE},
      '{"n",                   FREE,  slu_pkg::KIND_VARIABLE},
      '{slu_pkg::CHAR_HASH,    FREE,  slu_pkg::KIND_VARIABLE},
      '{8'h80,                 FREE,  slu_pkg::KIND_VARIABLE},
      '{slu_pkg::CHAR_HASH,    FREE,  slu_pkg::KIND_VARIABLE},
      '{"r",                   FREE,  slu_pkg::KIND_VARIABLE},
      '{"e",                   FREE,  slu_pkg::KIND_VARIABLE},
      '{"c",                   FREE,  slu_pkg::KIND_VARIABLE},
      '{slu_pkg::CHAR_EOS,     FREE,  slu_pkg::KIND_VARIABLE},
      '{8'h7F,                 TYPED, slu_pkg::KIND_INVALID},
      '{"a",                   FREE,  slu_pkg::KIND_VARIABLE},
      '{slu_pkg::CHAR_NUL,     TYPED, slu_pkg::KIND_END}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_char_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [3:0]  rsp_token_kind;
   logic [1:0]  rsp_keyword_index;
   logic [15:0] rsp_word_start;
   logic [15:0] rsp_word_length;
   logic        rsp_last_of_run;

   logic steady_flow   = 1'b0;
   logic hold_request  = 1'b0;
   logic pressure_done = 1'b0;

   // lexer state as the bench tracks it
   slu_pkg::mode_type lex_mode     = slu_pkg::MODE_IDLE;
   logic [15:0]       next_pos     = '0;
   logic [15:0]       word_start_q = '0;
   logic [15:0]       word_len_q   = '0;
   logic [23:0]       prefix_q     = '0;

   slu_pkg::result_type step_tokens[$];
   slu_pkg::result_type expected_tokens[$];

   int bytes_taken   = 0;
   int lexed_bytes   = 0;
   int ignored_bytes = 0;
   int tokens_seen   = 0;
   int token_errors  = 0;
   int quiet_cycles  = 0;
   int kind_tally [16] = '{default: 0};

   symbol_language_lexer_unit u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_char_byte     (req_char_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_token_kind    (rsp_token_kind),
      .rsp_keyword_index (rsp_keyword_index),
      .rsp_word_start    (rsp_word_start),
      .rsp_word_length   (rsp_word_length),
      .rsp_last_of_run   (rsp_last_of_run)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic word_byte(input logic [7:0] b);
      return b >= slu_pkg::CHAR_FIRST && b <= slu_pkg::CHAR_LAST &&
             !(b inside {slu_pkg::CHAR_HASH, slu_pkg::CHAR_LPAREN, slu_pkg::CHAR_RPAREN,
                         slu_pkg::CHAR_LSQUARE, slu_pkg::CHAR_RSQUARE, slu_pkg::CHAR_SEMI});
   endfunction

   function automatic void clear_lexer();
      lex_mode     = slu_pkg::MODE_IDLE;
      next_pos     = '0;
      word_start_q = '0;
      word_len_q   = '0;
      prefix_q     = '0;
   endfunction

   function automatic void emit_token(input logic [3:0] kind, input logic [1:0] kw,
                                      input logic [15:0] start, input logic [15:0] len);
      step_tokens.push_back({kind, kw, start, len, 1'b0});
   endfunction

   // Work out the tokens one source byte gives and advance the lexer state.
   function automatic void lex_byte(input logic [7:0] b);
      logic [15:0] pos;
      logic        ends;
      logic [3:0]  kind;
      logic [1:0]  kw;
      pos      = next_pos;
      ends     = (b == slu_pkg::CHAR_NUL) || (b == slu_pkg::CHAR_EOS);
      next_pos = pos + 16'd1;
      step_tokens.delete();
      if (lex_mode == slu_pkg::MODE_HALTED || lex_mode == slu_pkg::MODE_COMMENT) begin
         if (ends) begin
            emit_token(slu_pkg::KIND_END, 2'd0, '0, '0);
            clear_lexer();
         end else if (lex_mode == slu_pkg::MODE_COMMENT && b == slu_pkg::CHAR_HASH) begin
            lex_mode = slu_pkg::MODE_IDLE;
         end
      end else if (lex_mode == slu_pkg::MODE_WORD && word_byte(b)) begin
         if (word_len_q < 16'd3) prefix_q = {prefix_q[15:0], b};
         if (word_len_q != 16'hFFFF) word_len_q = word_len_q + 16'd1;
      end else begin
         if (lex_mode == slu_pkg::MODE_WORD) begin
            kind = slu_pkg::KIND_KEYWORD;
            if (word_len_q == 16'd3 && prefix_q == slu_pkg::TEXT_FUN) kw = slu_pkg::KW_FUN;
            else if (word_len_q == 16'd3 && prefix_q == slu_pkg::TEXT_LET) kw = slu_pkg::KW_LET;
            else if (word_len_q == 16'd2 && prefix_q == slu_pkg::TEXT_IN) kw = slu_pkg::KW_IN;
            else if (word_len_q == 16'd3 && prefix_q == slu_pkg::TEXT_REC) kw = slu_pkg::KW_REC;
            else begin
               kind = slu_pkg::KIND_VARIABLE;
               kw   = 2'd0;
            end
            emit_token(kind, kw, word_start_q, word_len_q);
            lex_mode = slu_pkg::MODE_IDLE;
         end
         if (ends) begin
            emit_token(slu_pkg::KIND_END, 2'd0, '0, '0);
            clear_lexer();
         end else if (b == slu_pkg::CHAR_SPACE ||
                      (b >= slu_pkg::CHAR_TAB && b <= slu_pkg::CHAR_CR)) begin
         end else if (b == slu_pkg::CHAR_HASH) begin
            lex_mode = slu_pkg::MODE_COMMENT;
         end else if (b == slu_pkg::CHAR_LPAREN) begin
            emit_token(slu_pkg::KIND_LPAREN, 2'd0, '0, '0);
         end else if (b == slu_pkg::CHAR_RPAREN) begin
            emit_token(slu_pkg::KIND_RPAREN, 2'd0, '0, '0);
         end else if (b == slu_pkg::CHAR_LSQUARE) begin
            emit_token(slu_pkg::KIND_LSQUARE, 2'd0, '0, '0);
         end else if (b == slu_pkg::CHAR_RSQUARE) begin
            emit_token(slu_pkg::KIND_RSQUARE, 2'd0, '0, '0);
         end else if (b == slu_pkg::CHAR_SEMI) begin
            emit_token(slu_pkg::KIND_SEMI, 2'd0, '0, '0);
         end else if (word_byte(b)) begin
            lex_mode     = slu_pkg::MODE_WORD;
            word_start_q = pos;
            word_len_q   = 16'd1;
            prefix_q     = {16'h0000, b};
         end else begin
            emit_token(slu_pkg::KIND_INVALID, 2'd0, '0, '0);
            lex_mode     = slu_pkg::MODE_HALTED;
            word_start_q = '0;
            word_len_q   = '0;
            prefix_q     = '0;
         end
      end
   endfunction

   always @(posedge clock) begin : byte_intake
      slu_pkg::result_type tok;
      if (reset) begin
         clear_lexer();
      end else if (req_valid && !req_stall) begin
         if (lex_mode == slu_pkg::MODE_HALTED && req_char_byte != slu_pkg::CHAR_NUL &&
             req_char_byte != slu_pkg::CHAR_EOS)
            ignored_bytes++;
         else
            lexed_bytes++;
         lex_byte(req_char_byte);
         if (bytes_taken < ROW_COUNT && DIRECTED_ROWS[bytes_taken].typed) begin
            step_tokens.delete();
            step_tokens.push_back({DIRECTED_ROWS[bytes_taken].kind, 2'd0, 16'd0, 16'd0, 1'b0});
         end
         foreach (step_tokens[i]) begin
            tok      = step_tokens[i];
            tok.last = (i == step_tokens.size() - 1);
            expected_tokens.push_back(tok);
         end
         bytes_taken++;
      end
   end

   always @(posedge clock) begin : token_check
      slu_pkg::result_type got;
      slu_pkg::result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_token_kind, rsp_keyword_index, rsp_word_start, rsp_word_length,
                rsp_last_of_run};
         tokens_seen++;
         kind_tally[got.kind]++;
         if (expected_tokens.size() == 0) begin
            token_errors++;
            if (token_errors <= MAX_REPORTS)
               $display("token %0d not expected: kind %0d kw %0d start %0d len %0d last %0d",
                        tokens_seen, got.kind, got.keyword, got.start, got.length, got.last);
         end else begin
            want = expected_tokens.pop_front();
            if (got.kind !== want.kind || got.keyword !== want.keyword ||
                got.start !== want.start || got.length !== want.length ||
                got.last !== want.last) begin
               token_errors++;
               if (token_errors <= MAX_REPORTS)
                  $display("token %0d: expected kind %0d kw %0d start %0d len %0d last %0d, %s",
                           tokens_seen, want.kind, want.keyword, want.start, want.length,
                           want.last, $sformatf("got kind %0d kw %0d start %0d len %0d last %0d",
                           got.kind, got.keyword, got.start, got.length, got.last));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("no transaction for %0d cycles", IDLE_LIMIT);
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   function automatic int unsigned pick_gap();
      return steady_flow ? 0 : $urandom_range(0, 7);
   endfunction

   function automatic logic [7:0] random_word_byte();
      logic [7:0] c;
      do c = 8'($urandom_range(slu_pkg::CHAR_FIRST, slu_pkg::CHAR_LAST));
      while (!word_byte(c));
      return c;
   endfunction

   function automatic logic [7:0] random_blank();
      return ($urandom_range(0, 5) == 0) ? slu_pkg::CHAR_SPACE
                                         : 8'(slu_pkg::CHAR_TAB + $urandom_range(0, 4));
   endfunction

   function automatic logic [7:0] random_punct();
      case ($urandom_range(0, 4))
         0:       return slu_pkg::CHAR_LPAREN;
         1:       return slu_pkg::CHAR_RPAREN;
         2:       return slu_pkg::CHAR_LSQUARE;
         3:       return slu_pkg::CHAR_RSQUARE;
         default: return slu_pkg::CHAR_SEMI;
      endcase
   endfunction

   function automatic logic [7:0] random_end();
      return $urandom_range(0, 1) ? slu_pkg::CHAR_EOS : slu_pkg::CHAR_NUL;
   endfunction

   // Receiver: random stalls per transaction, one long hold on request.
   initial begin : receiver
      int unsigned wait_cycles;
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            hold_request <= 1'b0;
         end
         wait_cycles = pick_gap();
         if (wait_cycles != 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   task automatic send_byte(input logic [7:0] b);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_char_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_word();
      logic [23:0] text;
      int          len;
      int          keep;
      int unsigned pick;
      pick = $urandom_range(0, 9);
      case ($urandom_range(0, 3))
         0:       text = slu_pkg::TEXT_FUN;
         1:       text = slu_pkg::TEXT_LET;
         2:       text = slu_pkg::TEXT_IN;
         default: text = slu_pkg::TEXT_REC;
      endcase
      len = (text == slu_pkg::TEXT_IN) ? 2 : 3;
      if (pick < 6) begin
         // keyword, keyword cut short, or keyword with a tail
         keep = (pick == 4) ? 1 : 0;
         for (int i = len - 1; i >= keep; i--) send_byte(text[8*i +: 8]);
         if (pick == 5) send_byte(random_word_byte());
      end else begin
         len = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 300) : $urandom_range(1, 6);
         repeat (len) send_byte(random_word_byte());
      end
   endtask

   task automatic send_comment();
      logic [7:0] c;
      send_byte(slu_pkg::CHAR_HASH);
      repeat ($urandom_range(0, 6)) begin
         do c = 8'($urandom_range(0, 255));
         while (c == slu_pkg::CHAR_HASH || c == slu_pkg::CHAR_NUL || c == slu_pkg::CHAR_EOS);
         send_byte(c);
      end
      send_byte(($urandom_range(0, 9) == 0) ? random_end() : slu_pkg::CHAR_HASH);
   endtask

   task automatic send_phrase();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
         send_word();
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: send_byte(random_blank());
            5, 6, 7:       send_byte(random_punct());
            8:             send_comment();
            default:       send_byte(random_end());
         endcase
      end else if (pick < 65) begin
         send_byte(random_punct());
      end else if (pick < 75) begin
         send_byte(random_blank());
      end else if (pick < 85) begin
         send_comment();
      end else if (pick < 92) begin
         send_byte(random_end());
      end else begin
         // noise, sometimes followed by junk and an end byte
         send_byte(8'($urandom_range(0, 255)));
         if ($urandom_range(0, 1)) begin
            repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(0, 255)));
            send_byte(random_end());
         end
      end
   endtask

   initial begin : stimulus
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      foreach (DIRECTED_ROWS[i]) send_byte(DIRECTED_ROWS[i].char_byte);

      while (lexed_bytes < ROW_COUNT + RANDOM_ITEMS) begin
         if (!pressure_done && lexed_bytes >= ROW_COUNT + RANDOM_ITEMS / 2) begin
            // hold the receiver and keep offering punctuation to fill the block
            pressure_done = 1'b1;
            send_byte(slu_pkg::CHAR_EOS);
            steady_flow  <= 1'b1;
            hold_request <= 1'b1;
            repeat (40) send_byte(random_punct());
            steady_flow <= 1'b0;
         end else if ($urandom_range(0, 29) == 0) begin
            steady_flow <= ($urandom_range(0, 4) == 0);
         end
         send_phrase();
      end

      send_byte(slu_pkg::CHAR_NUL);
      send_word();
      send_byte(slu_pkg::CHAR_SEMI);
      send_word();
      send_byte(slu_pkg::CHAR_EOS);

      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_tokens.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Lexed %0d bytes (%0d dropped while halted), checked %0d tokens.",
               lexed_bytes, ignored_bytes, tokens_seen);
      $display("Tokens: %0d keywords, %0d variables, %0d invalid, %0d ends; %0d errors, %0d missing.",
               kind_tally[slu_pkg::KIND_KEYWORD], kind_tally[slu_pkg::KIND_VARIABLE],
               kind_tally[slu_pkg::KIND_INVALID], kind_tally[slu_pkg::KIND_END],
               token_errors, expected_tokens.size());
      if (token_errors == 0 && expected_tokens.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
